/* hw/rtl/kscl_pkg.sv */
// Shared types, constants and the key layout table for the keypad scanner and code lock.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package kscl_pkg;

    // Number of keys in one code entry.
    localparam int CODE_LENGTH = 8;

    // Wide enough to count up to CODE_LENGTH, never narrower than the 4-bit port.
    localparam int KEY_CNT_W = ($clog2(CODE_LENGTH + 1) > 4) ? $clog2(CODE_LENGTH + 1) : 4;

    localparam logic [KEY_CNT_W-1:0] KEY_CNT_LAST = KEY_CNT_W'(CODE_LENGTH);
    localparam logic [3:0]           KEYS_DONE    = 4'(CODE_LENGTH % 16);

    localparam logic [7:0]  DEBOUNCE_RESET = 8'd20;
    localparam logic [31:0] CODE_RESET     = 32'hE6FC_9350;

    // Configuration register indices.
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_CODE     = 2'd1;

    localparam logic [3:0] COLS_IDLE   = 4'hF;
    localparam logic [3:0] DRIVE_IDLE  = 4'h0;
    localparam logic [3:0] DRIVE_ROW0  = 4'hE;
    localparam logic [1:0] ROW_LAST    = 2'd3;

    typedef struct packed {
        logic [3:0] row_drive;
        logic       key_valid;
        logic [3:0] key_code;
        logic [6:0] key_char;
        logic [3:0] keys_entered;
        logic       verdict_valid;
        logic       access_granted;
    } t_result;

    // Layout "123A" "456B" "789C" "*0#D", indexed by row*4+column.
    function automatic logic [6:0] key_char_of(input logic [3:0] code);
        logic [6:0] ch;
        case (code)
            4'd0:    ch = 7'h31;
            4'd1:    ch = 7'h32;
            4'd2:    ch = 7'h33;
            4'd3:    ch = 7'h41;
            4'd4:    ch = 7'h34;
            4'd5:    ch = 7'h35;
            4'd6:    ch = 7'h36;
            4'd7:    ch = 7'h42;
            4'd8:    ch = 7'h37;
            4'd9:    ch = 7'h38;
            4'd10:   ch = 7'h39;
            4'd11:   ch = 7'h43;
            4'd12:   ch = 7'h2A;
            4'd13:   ch = 7'h30;
            4'd14:   ch = 7'h23;
            default: ch = 7'h44;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/kscl_fsm.sv */
// Scan sequencer and code comparison: one state step per accepted column sample.
// Depends on kscl_pkg; holds the configuration registers and produces the result beat.
`default_nettype none

module kscl_fsm import kscl_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic [3:0]  i_col_lines,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output t_result          o_result
);

    typedef enum logic [1:0] {
        PH_RELEASE,
        PH_PRESS,
        PH_DEBOUNCE,
        PH_SCAN
    } t_phase;

    t_phase                 r_phase,       n_phase;
    logic [7:0]             r_deb_count,   n_deb_count;
    logic [1:0]             r_col_found,   n_col_found;
    logic [1:0]             r_row_found,   n_row_found;
    logic [1:0]             r_scan_row,    n_scan_row;
    logic [KEY_CNT_W-1:0]   r_key_count,   n_key_count;
    logic                   r_mismatch,    n_mismatch;
    logic [7:0]             r_deb_ticks;
    logic [31:0]            r_code_word;

    logic [3:0]             key_code;
    logic [3:0]             expected;
    logic [KEY_CNT_W-1:0]   count_inc;
    t_result                res;

    always_comb begin
        n_phase     = r_phase;
        n_deb_count = r_deb_count;
        n_col_found = r_col_found;
        n_row_found = r_row_found;
        n_scan_row  = r_scan_row;
        n_key_count = r_key_count;
        n_mismatch  = r_mismatch;
        res         = '0;
        res.row_drive = DRIVE_IDLE;
        key_code    = '0;
        expected    = r_code_word[{r_key_count[2:0], 2'b00} +: 4];
        count_inc   = r_key_count + KEY_CNT_W'(1);

        case (r_phase)
            PH_RELEASE: begin
                if (i_col_lines == COLS_IDLE) begin
                    n_phase = PH_PRESS;
                end
            end
            PH_PRESS: begin
                if (i_col_lines != COLS_IDLE) begin
                    n_deb_count = r_deb_ticks;
                    n_phase     = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE: begin
                if (r_deb_count != 8'd0) begin
                    n_deb_count = r_deb_count - 8'd1;
                end else begin
                    // Lowest-numbered column wins; a released key leaves the old column.
                    if (!i_col_lines[3]) begin
                        n_col_found = 2'd0;
                    end else if (!i_col_lines[2]) begin
                        n_col_found = 2'd1;
                    end else if (!i_col_lines[1]) begin
                        n_col_found = 2'd2;
                    end else if (!i_col_lines[0]) begin
                        n_col_found = 2'd3;
                    end
                    n_scan_row    = 2'd0;
                    res.row_drive = DRIVE_ROW0;
                    n_phase       = PH_SCAN;
                end
            end
            PH_SCAN: begin
                if (i_col_lines != COLS_IDLE) begin
                    n_row_found = r_scan_row;
                end
                if (r_scan_row != ROW_LAST) begin
                    n_scan_row    = r_scan_row + 2'd1;
                    res.row_drive = ~(4'b0001 << n_scan_row);
                end else begin
                    key_code     = {n_row_found, r_col_found};
                    res.key_valid = 1'b1;
                    res.key_code  = key_code;
                    res.key_char  = key_char_of(key_code);
                    n_mismatch    = r_mismatch | (expected != key_code);
                    n_key_count   = count_inc;
                    if (count_inc >= KEY_CNT_LAST) begin
                        res.verdict_valid  = 1'b1;
                        res.access_granted = ~n_mismatch;
                        n_key_count        = '0;
                        n_mismatch         = 1'b0;
                    end
                    n_scan_row = 2'd0;
                    n_phase    = PH_RELEASE;
                end
            end
            default: begin
                n_phase = PH_RELEASE;
            end
        endcase

        res.keys_entered = res.verdict_valid ? KEYS_DONE : n_key_count[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RELEASE;
            r_deb_count <= '0;
            r_col_found <= '0;
            r_row_found <= '0;
            r_scan_row  <= '0;
            r_key_count <= '0;
            r_mismatch  <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_deb_count <= n_deb_count;
            r_col_found <= n_col_found;
            r_row_found <= n_row_found;
            r_scan_row  <= n_scan_row;
            r_key_count <= n_key_count;
            r_mismatch  <= n_mismatch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb_ticks <= DEBOUNCE_RESET;
            r_code_word <= CODE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DEBOUNCE: r_deb_ticks <= i_cfg_data[7:0];
                REG_CODE:     r_code_word <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    assign o_result = res;

endmodule

`default_nettype wire

/* hw/rtl/kscl_out_reg.sv */
// Result register with valid/ready handshake towards the consumer.
// Depends on kscl_pkg for the result beat type.
`default_nettype none

module kscl_out_reg import kscl_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_out_ready,
    output logic         o_can_load,
    output logic         o_out_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_data;

    // A new beat may enter when the register is empty or is being emptied now.
    assign o_can_load = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_data;

endmodule

`default_nettype wire

/* hw/rtl/keypad_scan_code_lock_top.sv */
// Top level of the 4x4 keypad scanner with eight-key code lock.
// Depends on kscl_pkg, kscl_fsm and kscl_out_reg.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+--------------------------------------------
//  input    | i_in_valid / o_in_ready   | i_col_lines
//  output   | o_out_valid / i_out_ready | o_row_drive .. o_access_granted
//  config   | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
// Every input beat yields one output beat in the following cycle; with the consumer ready a
// beat is taken in every cycle. The state step is one pass of logic into the result register.
// Reset (synchronous, active low) restores the register defaults and the release phase.
// While the result register is full and not taken, o_in_ready is low and the state holds.
`default_nettype none

module keypad_scan_code_lock_top import kscl_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_col_lines,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_row_drive,
    output logic             o_key_valid,
    output logic [3:0]       o_key_code,
    output logic [6:0]       o_key_char,
    output logic [3:0]       o_keys_entered,
    output logic             o_verdict_valid,
    output logic             o_access_granted,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic    step;
    logic    can_load;
    t_result step_result;
    t_result out_result;

    assign o_in_ready = can_load;
    assign step       = i_in_valid && can_load;

    kscl_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_col_lines (i_col_lines),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (step_result)
    );

    kscl_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step),
        .i_result    (step_result),
        .i_out_ready (i_out_ready),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_row_drive      = out_result.row_drive;
    assign o_key_valid      = out_result.key_valid;
    assign o_key_code       = out_result.key_code;
    assign o_key_char       = out_result.key_char;
    assign o_keys_entered   = out_result.keys_entered;
    assign o_verdict_valid  = out_result.verdict_valid;
    assign o_access_granted = out_result.access_granted;

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for keypad_scan_code_lock_top: column beats in, one result beat out.
// Depends on kscl_pkg and the RTL of the block; a scoreboard class predicts every result beat.
// Stimulus is a directed opening followed by randomised key entries under several settings.

module testbench;

    import kscl_pkg::*;

    localparam logic [1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [1:0] REG_UNMAPPED_HI = 2'd3;
    localparam int         BEAT_TARGET     = 1800;
    localparam int         STALL_LIMIT     = 4000;

    typedef enum logic [2:0] {
        SCAN_RELEASE,
        SCAN_PRESS,
        SCAN_DEBOUNCE,
        SCAN_ROWS
    } scan_phase_e;

    typedef enum int {
        ENTRY_CORRECT,
        ENTRY_ONE_WRONG,
        ENTRY_RANDOM
    } entry_mode_e;

    class lock_scoreboard;
        logic [7:0]  bounce_ticks;
        logic [31:0] code_word;
        scan_phase_e phase;
        logic [7:0]  bounce_left;
        logic [1:0]  col_hit;
        logic [1:0]  row_hit;
        logic [1:0]  row_idx;
        int          entered;
        logic        wrong_key;
        string       layout;
        t_result     pending[$];
        int          errors;

        function new();
            layout       = "123A456B789C*0#D";
            errors       = 0;
            bounce_ticks = DEBOUNCE_RESET;
            code_word    = CODE_RESET;
            phase        = SCAN_RELEASE;
            bounce_left  = '0;
            col_hit      = '0;
            row_hit      = '0;
            row_idx      = '0;
            entered      = 0;
            wrong_key    = 1'b0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] data);
            if (idx == REG_DEBOUNCE) begin
                bounce_ticks = data[7:0];
            end else if (idx == REG_CODE) begin
                code_word = data;
            end
        endfunction

        function bit idle();
            return pending.size() == 0;
        endfunction

        // Advances the lock by one accepted column beat and queues the result it produces.
        function void note_column_beat(logic [3:0] cols);
            t_result    exp;
            logic [3:0] code_nib;
            byte        ch;
            exp = '0;
            case (phase)
                SCAN_RELEASE: begin
                    if (cols == COLS_IDLE) phase = SCAN_PRESS;
                end
                SCAN_PRESS: begin
                    if (cols != COLS_IDLE) begin
                        bounce_left = bounce_ticks;
                        phase       = SCAN_DEBOUNCE;
                    end
                end
                SCAN_DEBOUNCE: begin
                    if (bounce_left != 0) begin
                        bounce_left = bounce_left - 8'd1;
                    end else begin
                        // Column 0 sits on bit 3; with nothing low the old column stays.
                        if (!cols[3]) col_hit = 2'd0;
                        else if (!cols[2]) col_hit = 2'd1;
                        else if (!cols[1]) col_hit = 2'd2;
                        else if (!cols[0]) col_hit = 2'd3;
                        row_idx       = '0;
                        exp.row_drive = DRIVE_ROW0;
                        phase         = SCAN_ROWS;
                    end
                end
                SCAN_ROWS: begin
                    if (cols != COLS_IDLE) row_hit = row_idx;
                    if (row_idx != ROW_LAST) begin
                        row_idx       = row_idx + 2'd1;
                        exp.row_drive = ~(4'b0001 << row_idx);
                    end else begin
                        exp.key_valid = 1'b1;
                        exp.key_code  = {row_hit, col_hit};
                        ch            = layout[exp.key_code];
                        exp.key_char  = ch[6:0];
                        code_nib      = code_word[(entered % 8) * 4 +: 4];
                        if (code_nib != exp.key_code) wrong_key = 1'b1;
                        entered = entered + 1;
                        if (entered >= CODE_LENGTH) begin
                            exp.verdict_valid  = 1'b1;
                            exp.access_granted = !wrong_key;
                            entered            = 0;
                            wrong_key          = 1'b0;
                        end
                        row_idx = '0;
                        phase   = SCAN_RELEASE;
                    end
                end
                default: phase = SCAN_RELEASE;
            endcase
            exp.keys_entered = exp.verdict_valid ? KEYS_DONE : 4'(entered);
            pending.push_back(exp);
        endfunction

        function void compare_field(string name, logic [6:0] exp, logic [6:0] act);
            if (exp !== act) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (pending.size() == 0) begin
                $error("result beat arrived with nothing outstanding");
                errors++;
                return;
            end
            exp = pending.pop_front();
            compare_field("row_drive", 7'(exp.row_drive), 7'(got.row_drive));
            compare_field("key_valid", 7'(exp.key_valid), 7'(got.key_valid));
            compare_field("key_code", 7'(exp.key_code), 7'(got.key_code));
            compare_field("key_char", exp.key_char, got.key_char);
            compare_field("keys_entered", 7'(exp.keys_entered), 7'(got.keys_entered));
            compare_field("verdict_valid", 7'(exp.verdict_valid), 7'(got.verdict_valid));
            compare_field("access_granted", 7'(exp.access_granted), 7'(got.access_granted));
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        in_valid    = 1'b0;
    logic [3:0]  col_lines   = 4'hF;
    logic        out_ready   = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [1:0]  cfg_index   = '0;
    logic [31:0] cfg_data    = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [3:0]  o_row_drive;
    logic        o_key_valid;
    logic [3:0]  o_key_code;
    logic [6:0]  o_key_char;
    logic [3:0]  o_keys_entered;
    logic        o_verdict_valid;
    logic        o_access_granted;

    lock_scoreboard sb;
    bit             calm         = 1'b0;
    int             beats_sent   = 0;
    int             quiet_cycles = 0;
    int             ready_left   = 0;
    int             key_pos      = 0;
    int             wrong_slot   = 0;
    entry_mode_e    entry_mode   = ENTRY_CORRECT;
    logic [7:0]     cur_debounce = DEBOUNCE_RESET;
    logic [31:0]    cur_code     = CODE_RESET;

    keypad_scan_code_lock_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_col_lines      (col_lines),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_row_drive      (o_row_drive),
        .o_key_valid      (o_key_valid),
        .o_key_code       (o_key_code),
        .o_key_char       (o_key_char),
        .o_keys_entered   (o_keys_entered),
        .o_verdict_valid  (o_verdict_valid),
        .o_access_granted (o_access_granted),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        int stall;
        if (ready_left > 0) begin
            ready_left--;
        end else if (calm || !out_ready) begin
            out_ready <= 1'b1;
            ready_left = $urandom_range(1, 40);
        end else begin
            stall = pick_gap();
            if (stall == 0) begin
                ready_left = $urandom_range(1, 20);
            end else begin
                out_ready <= 1'b0;
                ready_left = stall - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result seen;
        bit      moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_out_valid && out_ready) begin
                seen = {o_row_drive, o_key_valid, o_key_code, o_key_char,
                        o_keys_entered, o_verdict_valid, o_access_granted};
                sb.check_result(seen);
                moved = 1'b1;
            end
            if (in_valid && o_in_ready) begin
                sb.note_column_beat(col_lines);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic [3:0] cols);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        col_lines <= cols;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        beats_sent++;
    endtask

    // Holds the sender off until every outstanding result beat has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (!sb.idle()) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_register(idx, data);
        if (idx == REG_DEBOUNCE) cur_debounce = data[7:0];
        else if (idx == REG_CODE) cur_code = data;
        @(posedge i_clk);
    endtask

    // One well-formed press of the given key, with random content wherever the lock ignores it.
    task automatic press_key(input logic [3:0] key);
        logic [1:0] row;
        logic [3:0] sample;
        logic [3:0] beat;
        int         ci;
        bit         no_hit;
        row = key[3:2];
        ci  = key[1:0];
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_beat(4'($urandom_range(0, 14)));
        end
        repeat ($urandom_range(1, 2)) send_beat(COLS_IDLE);
        send_beat(4'($urandom_range(0, 14)));
        repeat (cur_debounce) send_beat(4'($urandom));
        if ($urandom_range(0, 19) == 0) begin
            // Key let go before the column sample.
            sample = COLS_IDLE;
        end else begin
            sample = 4'($urandom);
            sample[3 - ci] = 1'b0;
            for (int b = 3; b > 3 - ci; b--) sample[b] = 1'b1;
        end
        send_beat(sample);
        no_hit = ($urandom_range(0, 19) == 0);
        for (int r = 0; r < 4; r++) begin
            if (no_hit || r > row) beat = COLS_IDLE;
            else if (r == row) beat = 4'($urandom_range(0, 14));
            else beat = 4'($urandom);
            send_beat(beat);
        end
        key_pos++;
    endtask

    task automatic next_key();
        logic [3:0] key;
        int         slot;
        slot = key_pos % 8;
        if (slot == 0) begin
            case ($urandom_range(0, 3))
                0, 1:    entry_mode = ENTRY_CORRECT;
                2:       entry_mode = ENTRY_ONE_WRONG;
                default: entry_mode = ENTRY_RANDOM;
            endcase
            wrong_slot = $urandom_range(0, 7);
        end
        key = cur_code[slot * 4 +: 4];
        if (entry_mode == ENTRY_RANDOM) key = 4'($urandom);
        else if (entry_mode == ENTRY_ONE_WRONG && slot == wrong_slot)
            key = key ^ 4'($urandom_range(1, 15));
        if ($urandom_range(0, 9) == 0) calm = !calm;
        if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 6)) send_beat(4'($urandom));
        end
        if ($urandom_range(0, 49) == 0) drain_results();
        press_key(key);
    endtask

    initial begin
        logic [3:0]  opening[22] = '{
            4'h0, 4'hF, 4'h0, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF,
            4'hF, 4'h7, 4'hE, 4'h0, 4'hF, 4'h0, 4'hF,
            4'hF, 4'hB, 4'h0, 4'hF, 4'hF, 4'hF, 4'h0
        };
        logic [31:0] code_pick;
        logic [7:0]  bounce_pick;
        int          nkeys;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(REG_DEBOUNCE, 32'h0);
        write_reg(REG_UNMAPPED_LO, 32'hFFFF_FFFF);
        write_reg(REG_UNMAPPED_HI, $urandom);

        // Opening: a release during debounce with no row hit, then keys 'C' and '*'.
        foreach (opening[i]) send_beat(opening[i]);

        for (int ph = 0; beats_sent < BEAT_TARGET; ph++) begin
            drain_results();
            repeat (2) @(posedge i_clk);
            case (ph)
                0: begin
                    bounce_pick = 8'd0;
                    code_pick   = 32'h0;
                    nkeys       = 24;
                end
                1: begin
                    bounce_pick = 8'hFF;
                    code_pick   = 32'hFFFF_FFFF;
                    nkeys       = 1;
                end
                2: begin
                    bounce_pick = DEBOUNCE_RESET;
                    code_pick   = CODE_RESET;
                    nkeys       = 8;
                end
                default: begin
                    bounce_pick = 8'($urandom_range(0, 4));
                    code_pick   = $urandom;
                    if ($urandom_range(0, 3) == 0) code_pick = {8{4'($urandom)}};
                    nkeys       = $urandom_range(16, 32);
                end
            endcase
            write_reg(REG_DEBOUNCE, {24'h0, bounce_pick});
            write_reg(REG_CODE, code_pick);
            key_pos = sb.entered;
            repeat (nkeys) next_key();
        end

        calm = 1'b0;
        drain_results();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* keypad_scan_code_lock_top.f */
hw/rtl/kscl_pkg.sv
hw/rtl/kscl_fsm.sv
hw/rtl/kscl_out_reg.sv
hw/rtl/keypad_scan_code_lock_top.sv
dv/testbench.sv
